// ===== src/tccw_pkg.sv =====
// Shared types and constants for the text console cell writer.
// No dependencies; used by tccw_step and text_console_cell_writer_core.
package tccw_pkg;

   // Field widths fixed by the console interface
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int ADDR_W = 11;
   localparam int BYTE_W = 8;
   localparam int FUNC_W = 2;

   // Function selector codes
   localparam logic [FUNC_W-1:0] FUNC_PUTCHAR  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE_AT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd2;

   // Character and attribute codes
   localparam logic [BYTE_W-1:0] CHR_NEWLINE   = 8'h0A;
   localparam logic [BYTE_W-1:0] CHR_BACKSPACE = 8'h08;
   localparam logic [BYTE_W-1:0] CHR_SPACE     = 8'h20;
   localparam logic [BYTE_W-1:0] CHR_PRINT_HI  = 8'h7F;
   localparam logic [BYTE_W-1:0] CLEAR_ATTR    = 8'h07;

   // One request item
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [BYTE_W-1:0] chr;
      logic [BYTE_W-1:0] color;
      logic [COL_W-1:0]  col_in;
      logic [ROW_W-1:0]  row_in;
   } req_type;

   // One result item
   typedef struct packed {
      logic              cell_write;
      logic [ADDR_W-1:0] cell_addr;
      logic [BYTE_W-1:0] cell_char;
      logic [BYTE_W-1:0] cell_attr;
      logic              clear_all;
      logic [ADDR_W-1:0] cursor_pos;
      logic              rejected;
   } rsp_type;

   // Cursor and current attribute
   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [BYTE_W-1:0] attr;
   } cursor_type;

endpackage

// ===== src/tccw_step.sv =====
// Per-item console logic: next cursor state and the result for one request.
// Depends on tccw_pkg.
module tccw_step #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  tccw_pkg::req_type    req,
   input  tccw_pkg::cursor_type cur,
   output tccw_pkg::cursor_type nxt,
   output tccw_pkg::rsp_type    rsp
);
   import tccw_pkg::*;

   localparam int                IDX_W    = ROW_W + COL_W;
   localparam logic [COL_W-1:0]  COL_LAST = COL_W'(COLS - 1);
   localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  COL_LIM  = COL_W'(COLS);
   localparam logic [ROW_W-1:0]  ROW_LIM  = ROW_W'(ROWS);
   localparam logic [IDX_W-1:0]  COLS_X   = IDX_W'(COLS);

   logic [ROW_W-1:0] adv_row_src;
   logic [COL_W-1:0] adv_col_src;
   logic [ROW_W-1:0] adv_row;
   logic [COL_W-1:0] adv_col;
   logic [ROW_W-1:0] nl_row;
   logic [ROW_W-1:0] bs_row;
   logic [COL_W-1:0] bs_col;
   logic [ROW_W-1:0] wr_row;
   logic [COL_W-1:0] wr_col;
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] cur_idx;
   logic             is_print;
   logic             off_screen;

   // Advance source: write-at restarts from its target cell
   assign adv_row_src = (req.func == FUNC_WRITE_AT) ? req.row_in : cur.row;
   assign adv_col_src = (req.func == FUNC_WRITE_AT) ? req.col_in : cur.col;

   // Cursor advance with column then row wrap
   always_comb begin
      adv_row = adv_row_src;
      adv_col = adv_col_src + 1'b1;
      if (adv_col_src >= COL_LAST) begin
         adv_col = '0;
         adv_row = (adv_row_src >= ROW_LAST) ? '0 : adv_row_src + 1'b1;
      end
   end

   // Newline row and backspace position
   assign nl_row = (cur.row >= ROW_LAST) ? '0 : cur.row + 1'b1;

   always_comb begin
      bs_row = cur.row;
      bs_col = cur.col;
      if (cur.col != '0) begin
         bs_col = cur.col - 1'b1;
      end else if (cur.row != '0) begin
         bs_row = cur.row - 1'b1;
         bs_col = COL_LAST;
      end
   end

   assign is_print   = (req.chr >= CHR_SPACE) && (req.chr <= CHR_PRINT_HI);
   assign off_screen = (req.col_in >= COL_LIM) || (req.row_in >= ROW_LIM);

   // Main decode
   always_comb begin
      nxt            = cur;
      wr_row         = cur.row;
      wr_col         = cur.col;
      rsp.cell_write = 1'b0;
      rsp.cell_char  = '0;
      rsp.cell_attr  = '0;
      rsp.clear_all  = 1'b0;
      rsp.rejected   = 1'b0;
      case (req.func)
         FUNC_PUTCHAR: begin
            if (req.chr == CHR_NEWLINE) begin
               nxt.row = nl_row;
               nxt.col = '0;
            end else if (req.chr == CHR_BACKSPACE) begin
               nxt.row        = bs_row;
               nxt.col        = bs_col;
               wr_row         = bs_row;
               wr_col         = bs_col;
               rsp.cell_write = 1'b1;
               rsp.cell_char  = CHR_SPACE;
               rsp.cell_attr  = cur.attr;
            end else if (is_print) begin
               nxt.row        = adv_row;
               nxt.col        = adv_col;
               rsp.cell_write = 1'b1;
               rsp.cell_char  = req.chr;
               rsp.cell_attr  = cur.attr;
            end
         end
         FUNC_WRITE_AT: begin
            if (off_screen) begin
               rsp.rejected = 1'b1;
            end else begin
               nxt.row        = adv_row;
               nxt.col        = adv_col;
               nxt.attr       = req.color;
               wr_row         = req.row_in;
               wr_col         = req.col_in;
               rsp.cell_write = 1'b1;
               rsp.cell_char  = req.chr;
               rsp.cell_attr  = req.color;
            end
         end
         FUNC_CLEAR: begin
            nxt.row       = '0;
            nxt.col       = '0;
            nxt.attr      = CLEAR_ATTR;
            rsp.clear_all = 1'b1;
         end
         default: begin
            nxt = cur;
         end
      endcase

      // Cell indexes: row times COLS plus column, kept to the address width
      wr_idx         = IDX_W'(wr_row) * COLS_X + IDX_W'(wr_col);
      cur_idx        = IDX_W'(nxt.row) * COLS_X + IDX_W'(nxt.col);
      rsp.cell_addr  = rsp.cell_write ? wr_idx[ADDR_W-1:0] : '0;
      rsp.cursor_pos = cur_idx[ADDR_W-1:0];
   end

endmodule

// ===== src/text_console_cell_writer_core.sv =====
// Top level of the text console cell writer: input register, cursor state,
// result register. Depends on tccw_pkg and tccw_step.
//
// Text console writer for a COLS x ROWS character screen. Each request is a
// putchar at the cursor, a write at a given cell, or a clear; each gives
// exactly one result holding at most one cell write, a clear flag, a reject
// flag and the new cursor position. The block takes one request per clock
// unless the result side stalls, and returns its result through the two
// register stages (input register, then result register). One
// request per clock holds because the cursor update logic reads and writes
// the cursor state in a single cycle. A stall on the result side holds the
// result register and a full input register; the request side stalls only when both are full.
module text_console_cell_writer_core #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tccw_pkg::FUNC_W-1:0]   req_func,
   input  logic [tccw_pkg::BYTE_W-1:0]   req_chr,
   input  logic [tccw_pkg::BYTE_W-1:0]   req_color,
   input  logic [tccw_pkg::COL_W-1:0]    req_col_in,
   input  logic [tccw_pkg::ROW_W-1:0]    req_row_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_cell_write,
   output logic [tccw_pkg::ADDR_W-1:0]   rsp_cell_addr,
   output logic [tccw_pkg::BYTE_W-1:0]   rsp_cell_char,
   output logic [tccw_pkg::BYTE_W-1:0]   rsp_cell_attr,
   output logic                          rsp_clear_all,
   output logic [tccw_pkg::ADDR_W-1:0]   rsp_cursor_pos,
   output logic                          rsp_rejected
);
   import tccw_pkg::*;

   req_type    req_ff;
   req_type    req_in;
   logic       req_valid_ff;
   logic       req_valid_in;
   cursor_type cursor_ff;
   cursor_type cursor_in;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   cursor_type step_nxt;
   rsp_type    step_rsp;
   logic       advance;
   logic       req_take;

   // Pipeline moves whenever the result register is free or being drained
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   tccw_step #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_step (
      .req (req_ff),
      .cur (cursor_ff),
      .nxt (step_nxt),
      .rsp (step_rsp)
   );

   // Input register
   always_comb begin
      req_in       = req_ff;
      req_valid_in = req_valid_ff;
      if (req_take) begin
         req_in.func   = req_func;
         req_in.chr    = req_chr;
         req_in.color  = req_color;
         req_in.col_in = req_col_in;
         req_in.row_in = req_row_in;
      end
      if (advance || req_take) begin
         req_valid_in = req_take;
      end
   end

   // Cursor state and result register
   always_comb begin
      cursor_in    = cursor_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = req_valid_ff;
         if (req_valid_ff) begin
            cursor_in = step_nxt;
            rsp_in    = step_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cursor_ff    <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cursor_ff    <= cursor_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   // Result ports
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_write = rsp_ff.cell_write;
   assign rsp_cell_addr  = rsp_ff.cell_addr;
   assign rsp_cell_char  = rsp_ff.cell_char;
   assign rsp_cell_attr  = rsp_ff.cell_attr;
   assign rsp_clear_all  = rsp_ff.clear_all;
   assign rsp_cursor_pos = rsp_ff.cursor_pos;
   assign rsp_rejected   = rsp_ff.rejected;

endmodule

// ===== tb/text_console_cell_writer_core_tb.sv =====
// Self-checking testbench for text_console_cell_writer_core: queue-fed driver,
// clocked monitor and a cursor/attribute predictor. Depends on tccw_pkg and text_console_cell_writer_core.
module text_console_cell_writer_core_tb;
   import tccw_pkg::*;

   localparam int CON_COLS = 80;
   localparam int CON_ROWS = 25;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 10;
   localparam int PHASE_ITEMS = 420;
   localparam int MAX_REPORTS = 10;
   // Selector code the block treats as no-op
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid  = 1'b0;
   logic                 req_stall;
   logic [FUNC_W-1:0]    req_func   = '0;
   logic [BYTE_W-1:0]    req_chr    = '0;
   logic [BYTE_W-1:0]    req_color  = '0;
   logic [COL_W-1:0]     req_col_in = '0;
   logic [ROW_W-1:0]     req_row_in = '0;
   logic                 rsp_valid;
   logic                 rsp_stall  = 1'b0;
   logic                 rsp_cell_write;
   logic [ADDR_W-1:0]    rsp_cell_addr;
   logic [BYTE_W-1:0]    rsp_cell_char;
   logic [BYTE_W-1:0]    rsp_cell_attr;
   logic                 rsp_clear_all;
   logic [ADDR_W-1:0]    rsp_cursor_pos;
   logic                 rsp_rejected;

   // Console commands waiting to be sent, and screen updates expected back
   req_type pending_cmds[$];
   rsp_type expected_updates[$];

   // Predicted console state
   logic [ROW_W-1:0]  cur_row  = '0;
   logic [COL_W-1:0]  cur_col  = '0;
   logic [BYTE_W-1:0] cur_attr = '0;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   req_type next_cmd;
   rsp_type seen_update;
   rsp_type want_update;

   text_console_cell_writer_core #(
      .COLS(CON_COLS),
      .ROWS(CON_ROWS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_chr(req_chr),
      .req_color(req_color),
      .req_col_in(req_col_in),
      .req_row_in(req_row_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_cell_write(rsp_cell_write),
      .rsp_cell_addr(rsp_cell_addr),
      .rsp_cell_char(rsp_cell_char),
      .rsp_cell_attr(rsp_cell_attr),
      .rsp_clear_all(rsp_clear_all),
      .rsp_cursor_pos(rsp_cursor_pos),
      .rsp_rejected(rsp_rejected)
   );

   always #1 clock = ~clock;

   function automatic logic [ADDR_W-1:0] cell_at(logic [ROW_W-1:0] row,
                                                 logic [COL_W-1:0] col);
      return ADDR_W'(int'(row) * CON_COLS + int'(col));
   endfunction

   // Step the cursor one cell, wrapping column then row
   function automatic void step_cursor();
      if (int'(cur_col) + 1 >= CON_COLS) begin
         cur_col = '0;
         if (int'(cur_row) + 1 >= CON_ROWS) cur_row = '0;
         else cur_row = cur_row + 1'b1;
      end else begin
         cur_col = cur_col + 1'b1;
      end
   endfunction

   // Screen update caused by one command; advances the predicted state
   function automatic rsp_type predict_screen_update(req_type cmd);
      rsp_type upd;
      upd = '0;
      case (cmd.func)
         FUNC_PUTCHAR: begin
            if (cmd.chr == CHR_NEWLINE) begin
               cur_col = '0;
               if (int'(cur_row) + 1 >= CON_ROWS) cur_row = '0;
               else cur_row = cur_row + 1'b1;
            end else if (cmd.chr == CHR_BACKSPACE) begin
               // stays put at the home cell
               if (cur_col != '0) begin
                  cur_col = cur_col - 1'b1;
               end else if (cur_row != '0) begin
                  cur_row = cur_row - 1'b1;
                  cur_col = COL_W'(CON_COLS - 1);
               end
               upd.cell_write = 1'b1;
               upd.cell_addr  = cell_at(cur_row, cur_col);
               upd.cell_char  = CHR_SPACE;
               upd.cell_attr  = cur_attr;
            end else if (cmd.chr >= CHR_SPACE && cmd.chr <= CHR_PRINT_HI) begin
               upd.cell_write = 1'b1;
               upd.cell_addr  = cell_at(cur_row, cur_col);
               upd.cell_char  = cmd.chr;
               upd.cell_attr  = cur_attr;
               step_cursor();
            end
         end
         FUNC_WRITE_AT: begin
            if (int'(cmd.col_in) >= CON_COLS || int'(cmd.row_in) >= CON_ROWS) begin
               upd.rejected = 1'b1;
            end else begin
               upd.cell_write = 1'b1;
               upd.cell_addr  = cell_at(cmd.row_in, cmd.col_in);
               upd.cell_char  = cmd.chr;
               upd.cell_attr  = cmd.color;
               cur_attr = cmd.color;
               cur_row  = cmd.row_in;
               cur_col  = cmd.col_in;
               step_cursor();
            end
         end
         FUNC_CLEAR: begin
            upd.clear_all = 1'b1;
            cur_row  = '0;
            cur_col  = '0;
            cur_attr = CLEAR_ATTR;
         end
         default: ;
      endcase
      upd.cursor_pos = cell_at(cur_row, cur_col);
      return upd;
   endfunction

   function automatic req_type console_cmd(logic [FUNC_W-1:0] func, logic [BYTE_W-1:0] chr,
                                           logic [BYTE_W-1:0] color, int col, int row);
      req_type cmd;
      cmd.func   = func;
      cmd.chr    = chr;
      cmd.color  = color;
      cmd.col_in = COL_W'(col);
      cmd.row_in = ROW_W'(row);
      return cmd;
   endfunction

   // Mostly well-formed console traffic, with some off-screen and odd bytes
   function automatic req_type random_cmd();
      req_type cmd;
      int pick;
      int sub;
      pick = $urandom_range(0, 99);
      sub  = $urandom_range(0, 99);
      cmd = console_cmd(FUNC_PUTCHAR, BYTE_W'($urandom_range(0, 255)),
                        BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 127),
                        $urandom_range(0, 31));
      if (pick < 62) begin
         if (sub < 70) cmd.chr = BYTE_W'($urandom_range(32'h20, 32'h7F));
         else if (sub < 80) cmd.chr = CHR_NEWLINE;
         else if (sub < 90) cmd.chr = CHR_BACKSPACE;
      end else if (pick < 88) begin
         cmd.func = FUNC_WRITE_AT;
         if (sub < 85) begin
            cmd.col_in = COL_W'($urandom_range(0, CON_COLS - 1));
            cmd.row_in = ROW_W'($urandom_range(0, CON_ROWS - 1));
         end
      end else if (pick < 95) begin
         cmd.func = FUNC_CLEAR;
      end else begin
         cmd.func = FUNC_UNUSED;
      end
      return cmd;
   endfunction

   // Driver: one transfer per accepted edge, next command chosen after it
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         if (req_valid && !req_stall)
            expected_updates.push_back(predict_screen_update(
               console_cmd(req_func, req_chr, req_color, req_col_in, req_row_in)));
         if (!req_valid || !req_stall) begin
            if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_cmd = pending_cmds.pop_front();
               req_func   <= next_cmd.func;
               req_chr    <= next_cmd.chr;
               req_color  <= next_cmd.color;
               req_col_in <= next_cmd.col_in;
               req_row_in <= next_cmd.row_in;
               req_valid  <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_update = '{rsp_cell_write, rsp_cell_addr, rsp_cell_char, rsp_cell_attr,
                         rsp_clear_all, rsp_cursor_pos, rsp_rejected};
         if (expected_updates.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display({"unexpected result: wr=%0d addr=%0d chr=%h attr=%h",
                         " clr=%0d cur=%0d rej=%0d"},
                        seen_update.cell_write, seen_update.cell_addr, seen_update.cell_char,
                        seen_update.cell_attr, seen_update.clear_all, seen_update.cursor_pos,
                        seen_update.rejected);
         end else begin
            want_update = expected_updates.pop_front();
            if (seen_update.cell_write !== want_update.cell_write ||
                seen_update.cell_addr  !== want_update.cell_addr  ||
                seen_update.cell_char  !== want_update.cell_char  ||
                seen_update.cell_attr  !== want_update.cell_attr  ||
                seen_update.clear_all  !== want_update.clear_all  ||
                seen_update.cursor_pos !== want_update.cursor_pos ||
                seen_update.rejected   !== want_update.rejected) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"mismatch: exp wr=%0d addr=%0d chr=%h attr=%h clr=%0d",
                            " cur=%0d rej=%0d | got wr=%0d addr=%0d chr=%h attr=%h",
                            " clr=%0d cur=%0d rej=%0d"},
                           want_update.cell_write, want_update.cell_addr,
                           want_update.cell_char, want_update.cell_attr,
                           want_update.clear_all, want_update.cursor_pos,
                           want_update.rejected, seen_update.cell_write,
                           seen_update.cell_addr, seen_update.cell_char,
                           seen_update.cell_attr, seen_update.clear_all,
                           seen_update.cursor_pos, seen_update.rejected);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb: failure");
         $finish;
      end
   end

   // Wait until every command is sent and every result has come back
   task automatic wait_drained();
      @(negedge clock);
      while (pending_cmds.size() > 0 || req_valid || expected_updates.size() > 0)
         @(negedge clock);
   endtask

   task automatic run_phase(int idle_pct, int hold_pct);
      int sent;
      int burst;
      send_idle_pct = idle_pct;
      stall_pct     = hold_pct;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         if ($urandom_range(0, 9) == 0) begin
            // a run of text long enough to wrap lines and rows
            burst = $urandom_range(30, 90);
            repeat (burst) begin
               pending_cmds.push_back(console_cmd(FUNC_PUTCHAR,
                  ($urandom_range(0, 15) == 0) ? CHR_NEWLINE
                                               : BYTE_W'($urandom_range(32'h20, 32'h7F)),
                  BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 127),
                  $urandom_range(0, 31)));
            end
            sent += burst;
         end else begin
            pending_cmds.push_back(random_cmd());
            sent++;
         end
      end
      wait_drained();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: edge cells, wraps, rejects, odd bytes, clear and no-op
      pending_cmds.push_back(console_cmd(FUNC_PUTCHAR, CHR_BACKSPACE, 8'h00, 0, 0));
      pending_cmds.push_back(console_cmd(FUNC_PUTCHAR, 8'h20, 8'hFF, 127, 31));
      pending_cmds.push_back(console_cmd(FUNC_PUTCHAR, 8'h7F, 8'h00, 0, 0));
      pending_cmds.push_back(console_cmd(FUNC_PUTCHAR, 8'h00, 8'h00, 0, 0));
      pending_cmds.push_back(console_cmd(FUNC_PUTCHAR, 8'h1F, 8'hFF, 127, 31));
      pending_cmds.push_back(console_cmd(FUNC_PUTCHAR, 8'h80, 8'h00, 0, 0));
      pending_cmds.push_back(console_cmd(FUNC_PUTCHAR, 8'hFF, 8'hFF, 127, 31));
      pending_cmds.push_back(console_cmd(FUNC_PUTCHAR, CHR_NEWLINE, 8'h00, 0, 0));
      pending_cmds.push_back(console_cmd(FUNC_PUTCHAR, CHR_BACKSPACE, 8'h00, 0, 0));
      pending_cmds.push_back(console_cmd(FUNC_WRITE_AT, 8'h41, 8'h1E, 79, 24));
      pending_cmds.push_back(console_cmd(FUNC_WRITE_AT, 8'h42, 8'h2C, 80, 0));
      pending_cmds.push_back(console_cmd(FUNC_WRITE_AT, 8'h43, 8'h3A, 127, 24));
      pending_cmds.push_back(console_cmd(FUNC_WRITE_AT, 8'h44, 8'h4B, 0, 25));
      pending_cmds.push_back(console_cmd(FUNC_WRITE_AT, 8'h45, 8'h5C, 127, 31));
      pending_cmds.push_back(console_cmd(FUNC_WRITE_AT, 8'h00, 8'hFF, 0, 0));
      pending_cmds.push_back(console_cmd(FUNC_WRITE_AT, 8'hFF, 8'h00, 5, 24));
      pending_cmds.push_back(console_cmd(FUNC_PUTCHAR, CHR_NEWLINE, 8'h00, 0, 0));
      pending_cmds.push_back(console_cmd(FUNC_WRITE_AT, 8'h61, 8'hA5, 78, 24));
      pending_cmds.push_back(console_cmd(FUNC_PUTCHAR, 8'h62, 8'h00, 0, 0));
      pending_cmds.push_back(console_cmd(FUNC_WRITE_AT, 8'h63, 8'h5A, 79, 3));
      pending_cmds.push_back(console_cmd(FUNC_PUTCHAR, CHR_BACKSPACE, 8'h00, 0, 0));
      pending_cmds.push_back(console_cmd(FUNC_PUTCHAR, CHR_BACKSPACE, 8'h00, 0, 0));
      pending_cmds.push_back(console_cmd(FUNC_CLEAR, 8'hFF, 8'hFF, 127, 31));
      pending_cmds.push_back(console_cmd(FUNC_PUTCHAR, 8'h5A, 8'h00, 0, 0));
      pending_cmds.push_back(console_cmd(FUNC_UNUSED, 8'hFF, 8'hFF, 127, 31));
      // sender holds off here until every result is back
      wait_drained();

      run_phase(0, 0);
      run_phase(79, 0);
      run_phase(0, 79);
      run_phase(24, 24);

      repeat (DRAIN_CYCLES) @(negedge clock);
      mismatch_count += expected_updates.size();
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/tccw_pkg.sv
src/tccw_step.sv
src/text_console_cell_writer_core.sv
tb/text_console_cell_writer_core_tb.sv
